[hdl/gbf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gbf_pkg
// Shared constants, types and register codes of the 5x5 Gaussian blur filter.
// ----------------------------------------------------------------------------
package gbf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_DIM    = 5;
  localparam int KERNEL     = 5;
  localparam int HALF       = KERNEL / 2;

  localparam int PIX_W      = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int WIDTH_W    = COL_W + 1;
  localparam int HEIGHT_W   = ROW_W + 1;
  localparam int WEIGHT_W   = 16;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 3;

  localparam int LINES      = KERNEL - 1;
  localparam int SLOT_W     = $clog2(LINES);

  localparam int SUM1_W     = PIX_W;
  localparam int SUM4_W     = PIX_W + 2;
  localparam int SUM8_W     = PIX_W + 3;
  localparam int PROD1_W    = SUM1_W + WEIGHT_W;
  localparam int PROD4_W    = SUM4_W + WEIGHT_W;
  localparam int PROD8_W    = SUM8_W + WEIGHT_W;
  localparam int ACC_W      = PIX_W + WEIGHT_W + 5;

  localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH      = WIDTH_W'(1024);
  localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT     = HEIGHT_W'(4096);
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_CORNER    = WEIGHT_W'(26);
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_OUT_NEAR  = WEIGHT_W'(216);
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_OUT_MID   = WEIGHT_W'(439);
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_IN_CORNER = WEIGHT_W'(1835);
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_IN_MID    = WEIGHT_W'(3742);
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_CENTER    = WEIGHT_W'(7196);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_WEIGHT_CORNER,
    REG_WEIGHT_OUTER_NEAR,
    REG_WEIGHT_OUTER_MID,
    REG_WEIGHT_INNER_CORNER,
    REG_WEIGHT_INNER_MID,
    REG_WEIGHT_CENTER
  } reg_idx_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [KERNEL-1:0][KERNEL-1:0] window_t;
  typedef pix_t [LINES-1:0] line_word_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] corner;
    logic [WEIGHT_W-1:0] outer_near;
    logic [WEIGHT_W-1:0] outer_mid;
    logic [WEIGHT_W-1:0] inner_corner;
    logic [WEIGHT_W-1:0] inner_mid;
    logic [WEIGHT_W-1:0] center;
  } weights_t;

  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } win_ctrl_t;

endpackage
`default_nettype wire

[hdl/gbf_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gbf_if
// Valid/ready channels of the blur filter: pixel input, result, register write.
// ----------------------------------------------------------------------------
interface gbf_pix_if;
  logic                valid;
  logic                ready;
  logic [gbf_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

interface gbf_res_if;
  logic                valid;
  logic                ready;
  logic [gbf_pkg::PIX_W-1:0] pixel_out;
  logic [gbf_pkg::ROW_W-1:0] out_row;
  logic [gbf_pkg::COL_W-1:0] out_col;

  modport source (output valid, output pixel_out, output out_row, output out_col, input ready);
  modport sink (input valid, input pixel_out, input out_row, input out_col, output ready);
endinterface

interface gbf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [gbf_pkg::CFG_IDX_W-1:0] index;
  logic [gbf_pkg::WEIGHT_W-1:0]  wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

[hdl/gbf_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gbf_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hdl/gbf_linebuf.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gbf_linebuf
// Raster position counters, four-line store and the 5x5 pixel window.
// ----------------------------------------------------------------------------
module gbf_linebuf (
  input  logic                             clk,
  input  logic                             rst,
  gbf_pix_if.sink                          pix,
  input  logic [gbf_pkg::WIDTH_W-1:0]      width,
  input  logic [gbf_pkg::HEIGHT_W-1:0]     height,
  output gbf_pkg::win_ctrl_t               win_ctrl,
  output gbf_pkg::window_t                 window,
  input  logic                             win_ready
);

  logic [gbf_pkg::COL_W-1:0]    col_count;
  logic [gbf_pkg::COL_W-1:0]    col_count_next;
  logic [gbf_pkg::ROW_W-1:0]    row_count;
  logic [gbf_pkg::ROW_W-1:0]    row_count_next;

  logic                         wrap_pre;
  logic [gbf_pkg::HEIGHT_W-1:0] row_pre;
  logic [gbf_pkg::ROW_W-1:0]    cur_row;
  logic [gbf_pkg::COL_W-1:0]    cur_col;
  logic [gbf_pkg::WIDTH_W-1:0]  col_inc;
  logic [gbf_pkg::HEIGHT_W-1:0] row_inc;
  logic                         cur_emit;

  logic                         s1_valid;
  gbf_pkg::pix_t                s1_pixel;
  logic [gbf_pkg::ROW_W-1:0]    s1_row;
  logic [gbf_pkg::COL_W-1:0]    s1_col;
  logic                         s1_emit;
  logic                         s1_adv;
  logic                         pix_accept;

  gbf_pkg::line_word_t          line_rdata;
  gbf_pkg::line_word_t          line_wdata;
  gbf_pkg::window_t             window_next;

  // Position of the incoming pixel, with wrap for a shrunken frame.
  always_comb begin
    wrap_pre = {1'b0, col_count} >= width;
    row_pre  = {1'b0, row_count} + gbf_pkg::HEIGHT_W'(wrap_pre);
    cur_row  = (row_pre >= height) ? '0 : row_pre[gbf_pkg::ROW_W-1:0];
    cur_col  = wrap_pre ? '0 : col_count;
    col_inc  = {1'b0, cur_col} + gbf_pkg::WIDTH_W'(1);
    row_inc  = {1'b0, cur_row} + gbf_pkg::HEIGHT_W'(1);
    if (col_inc >= width) begin
      col_count_next = '0;
      row_count_next = (row_inc >= height) ? '0 : row_inc[gbf_pkg::ROW_W-1:0];
    end else begin
      col_count_next = col_inc[gbf_pkg::COL_W-1:0];
      row_count_next = cur_row;
    end
    cur_emit = (cur_row >= gbf_pkg::ROW_W'(gbf_pkg::KERNEL - 1))
            && (cur_col >= gbf_pkg::COL_W'(gbf_pkg::KERNEL - 1));
  end

  assign s1_adv     = s1_valid && (!win_ctrl.valid || win_ready);
  assign pix.ready  = !s1_valid || s1_adv;
  assign pix_accept = pix.valid && pix.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      s1_valid  <= 1'b0;
    end else if (pix_accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
      s1_valid  <= 1'b1;
    end else if (s1_adv) begin
      s1_valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      s1_pixel <= pix.pixel_in;
      s1_row   <= cur_row;
      s1_col   <= cur_col;
      s1_emit  <= cur_emit;
    end
  end

  gbf_ram #(
    .WIDTH ($bits(gbf_pkg::line_word_t)),
    .DEPTH (gbf_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (line_wdata),
    .re    (pix_accept),
    .raddr (cur_col),
    .rdata (line_rdata)
  );

  // Shift the window left; new column from the line store and the new pixel.
  always_comb begin
    line_wdata = line_rdata;
    line_wdata[s1_row[gbf_pkg::SLOT_W-1:0]] = s1_pixel;
    for (int y = 0; y < gbf_pkg::KERNEL; y++) begin
      for (int x = 0; x < gbf_pkg::KERNEL - 1; x++) begin
        window_next[y][x] = window[y][x+1];
      end
    end
    for (int y = 0; y < gbf_pkg::LINES; y++) begin
      window_next[y][gbf_pkg::KERNEL-1] =
        line_rdata[s1_row[gbf_pkg::SLOT_W-1:0] + gbf_pkg::SLOT_W'(y)];
    end
    window_next[gbf_pkg::KERNEL-1][gbf_pkg::KERNEL-1] = s1_pixel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window         <= '0;
      win_ctrl.valid <= 1'b0;
    end else if (s1_adv) begin
      window         <= window_next;
      win_ctrl.valid <= s1_emit;
    end else if (win_ready) begin
      win_ctrl.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      win_ctrl.row <= s1_row - gbf_pkg::ROW_W'(gbf_pkg::HALF);
      win_ctrl.col <= s1_col - gbf_pkg::COL_W'(gbf_pkg::HALF);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    win_ctrl.valid && !win_ready |=> win_ctrl.valid && $stable(window))
    else $error("window changed under a pending transaction");

  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_col) && $stable(line_rdata))
    else $error("line store read data lost while stalled");

  assert property (@(posedge clk) disable iff (rst)
    pix_accept && s1_adv |-> cur_col != s1_col)
    else $error("line store read and write collide");

endmodule
`default_nettype wire

[hdl/gbf_mac.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gbf_mac
// Symmetric 5x5 weighted sum: class sums, six products, accumulate, saturate.
// ----------------------------------------------------------------------------
module gbf_mac (
  input  logic                clk,
  input  logic                rst,
  input  gbf_pkg::win_ctrl_t  win_ctrl,
  input  gbf_pkg::window_t    window,
  input  gbf_pkg::weights_t   weights,
  output logic                win_ready,
  gbf_res_if.source           res
);

  logic                          sum_valid;
  logic                          sum_adv;
  logic                          sum_free;
  logic [gbf_pkg::ROW_W-1:0]     sum_row;
  logic [gbf_pkg::COL_W-1:0]     sum_col;
  logic [gbf_pkg::SUM4_W-1:0]    sum_corner;
  logic [gbf_pkg::SUM8_W-1:0]    sum_outer_near;
  logic [gbf_pkg::SUM4_W-1:0]    sum_outer_mid;
  logic [gbf_pkg::SUM4_W-1:0]    sum_inner_corner;
  logic [gbf_pkg::SUM4_W-1:0]    sum_inner_mid;
  logic [gbf_pkg::SUM1_W-1:0]    sum_center;

  logic                          prod_valid;
  logic                          prod_adv;
  logic                          prod_free;
  logic [gbf_pkg::ROW_W-1:0]     prod_row;
  logic [gbf_pkg::COL_W-1:0]     prod_col;
  logic [gbf_pkg::PROD4_W-1:0]   prod_corner;
  logic [gbf_pkg::PROD8_W-1:0]   prod_outer_near;
  logic [gbf_pkg::PROD4_W-1:0]   prod_outer_mid;
  logic [gbf_pkg::PROD4_W-1:0]   prod_inner_corner;
  logic [gbf_pkg::PROD4_W-1:0]   prod_inner_mid;
  logic [gbf_pkg::PROD1_W-1:0]   prod_center;

  logic                          o_valid;
  logic                          o_free;
  logic [gbf_pkg::ACC_W-1:0]     acc;
  gbf_pkg::pix_t                 acc_sat;

  assign o_free    = !o_valid || res.ready;
  assign prod_adv  = prod_valid && o_free;
  assign prod_free = !prod_valid || prod_adv;
  assign sum_adv   = sum_valid && prod_free;
  assign sum_free  = !sum_valid || sum_adv;
  assign win_ready = sum_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid  <= 1'b0;
      prod_valid <= 1'b0;
      o_valid    <= 1'b0;
    end else begin
      if (sum_free) begin
        sum_valid <= win_ctrl.valid;
      end
      if (prod_free) begin
        prod_valid <= sum_valid;
      end
      if (o_free) begin
        o_valid <= prod_valid;
      end
    end
  end

  // Group taps that share a weight.
  always_ff @(posedge clk) begin
    if (sum_free && win_ctrl.valid) begin
      sum_row          <= win_ctrl.row;
      sum_col          <= win_ctrl.col;
      sum_corner       <= gbf_pkg::SUM4_W'(window[0][0]) + gbf_pkg::SUM4_W'(window[0][4])
                        + gbf_pkg::SUM4_W'(window[4][0]) + gbf_pkg::SUM4_W'(window[4][4]);
      sum_outer_near   <= gbf_pkg::SUM8_W'(window[0][1]) + gbf_pkg::SUM8_W'(window[0][3])
                        + gbf_pkg::SUM8_W'(window[4][1]) + gbf_pkg::SUM8_W'(window[4][3])
                        + gbf_pkg::SUM8_W'(window[1][0]) + gbf_pkg::SUM8_W'(window[3][0])
                        + gbf_pkg::SUM8_W'(window[1][4]) + gbf_pkg::SUM8_W'(window[3][4]);
      sum_outer_mid    <= gbf_pkg::SUM4_W'(window[0][2]) + gbf_pkg::SUM4_W'(window[4][2])
                        + gbf_pkg::SUM4_W'(window[2][0]) + gbf_pkg::SUM4_W'(window[2][4]);
      sum_inner_corner <= gbf_pkg::SUM4_W'(window[1][1]) + gbf_pkg::SUM4_W'(window[1][3])
                        + gbf_pkg::SUM4_W'(window[3][1]) + gbf_pkg::SUM4_W'(window[3][3]);
      sum_inner_mid    <= gbf_pkg::SUM4_W'(window[1][2]) + gbf_pkg::SUM4_W'(window[3][2])
                        + gbf_pkg::SUM4_W'(window[2][1]) + gbf_pkg::SUM4_W'(window[2][3]);
      sum_center       <= window[2][2];
    end
  end

  always_ff @(posedge clk) begin
    if (prod_free && sum_valid) begin
      prod_row          <= sum_row;
      prod_col          <= sum_col;
      prod_corner       <= gbf_pkg::PROD4_W'(sum_corner) * gbf_pkg::PROD4_W'(weights.corner);
      prod_outer_near   <= gbf_pkg::PROD8_W'(sum_outer_near)
                         * gbf_pkg::PROD8_W'(weights.outer_near);
      prod_outer_mid    <= gbf_pkg::PROD4_W'(sum_outer_mid)
                         * gbf_pkg::PROD4_W'(weights.outer_mid);
      prod_inner_corner <= gbf_pkg::PROD4_W'(sum_inner_corner)
                         * gbf_pkg::PROD4_W'(weights.inner_corner);
      prod_inner_mid    <= gbf_pkg::PROD4_W'(sum_inner_mid)
                         * gbf_pkg::PROD4_W'(weights.inner_mid);
      prod_center       <= gbf_pkg::PROD1_W'(sum_center) * gbf_pkg::PROD1_W'(weights.center);
    end
  end

  // Truncate the fraction, saturate at full scale.
  always_comb begin
    acc = gbf_pkg::ACC_W'(prod_corner) + gbf_pkg::ACC_W'(prod_outer_near)
        + gbf_pkg::ACC_W'(prod_outer_mid) + gbf_pkg::ACC_W'(prod_inner_corner)
        + gbf_pkg::ACC_W'(prod_inner_mid) + gbf_pkg::ACC_W'(prod_center);
    if (acc[gbf_pkg::ACC_W-1:gbf_pkg::FRAC_W+gbf_pkg::PIX_W] != '0) begin
      acc_sat = '1;
    end else begin
      acc_sat = acc[gbf_pkg::FRAC_W +: gbf_pkg::PIX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (o_free && prod_valid) begin
      res.pixel_out <= acc_sat;
      res.out_row   <= prod_row;
      res.out_col   <= prod_col;
    end
  end

  assign res.valid = o_valid;

  assert property (@(posedge clk) disable iff (rst)
    $rose(o_valid) |-> $past(prod_valid))
    else $error("result raised without a product stage transaction");

endmodule
`default_nettype wire

[hdl/gaussian_blur_5x5_filter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_blur_5x5_filter
// Path: the pixel that completes a 5x5 window passes the s1 stage, the window
//   register and the sum, product and output registers to its result.
// Throughput: one pixel per cycle while the result channel is not stalled,
//   set by the single read and single write port of the line store RAM.
// Reset: clears position counters, window, pipeline valids, registers to
//   defaults; line store contents are not cleared.
// ----------------------------------------------------------------------------
module gaussian_blur_5x5_filter (
  input  logic       clk,
  input  logic       rst,
  gbf_pix_if.sink    pix,
  gbf_res_if.source  res,
  gbf_cfg_if.sink    cfg
);

  logic [gbf_pkg::WIDTH_W-1:0]  image_width;
  logic [gbf_pkg::HEIGHT_W-1:0] image_height;
  logic [gbf_pkg::WIDTH_W-1:0]  eff_width;
  logic [gbf_pkg::HEIGHT_W-1:0] eff_height;
  gbf_pkg::weights_t            weights;
  gbf_pkg::win_ctrl_t           win_ctrl;
  gbf_pkg::window_t             window;
  logic                         win_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width          <= gbf_pkg::RST_IMAGE_WIDTH;
      image_height         <= gbf_pkg::RST_IMAGE_HEIGHT;
      weights.corner       <= gbf_pkg::RST_WEIGHT_CORNER;
      weights.outer_near   <= gbf_pkg::RST_WEIGHT_OUT_NEAR;
      weights.outer_mid    <= gbf_pkg::RST_WEIGHT_OUT_MID;
      weights.inner_corner <= gbf_pkg::RST_WEIGHT_IN_CORNER;
      weights.inner_mid    <= gbf_pkg::RST_WEIGHT_IN_MID;
      weights.center       <= gbf_pkg::RST_WEIGHT_CENTER;
    end else if (cfg.valid) begin
      case (gbf_pkg::reg_idx_t'(cfg.index))
        gbf_pkg::REG_IMAGE_WIDTH: begin
          image_width <= cfg.wdata[gbf_pkg::WIDTH_W-1:0];
        end
        gbf_pkg::REG_IMAGE_HEIGHT: begin
          image_height <= cfg.wdata[gbf_pkg::HEIGHT_W-1:0];
        end
        gbf_pkg::REG_WEIGHT_CORNER: begin
          weights.corner <= cfg.wdata;
        end
        gbf_pkg::REG_WEIGHT_OUTER_NEAR: begin
          weights.outer_near <= cfg.wdata;
        end
        gbf_pkg::REG_WEIGHT_OUTER_MID: begin
          weights.outer_mid <= cfg.wdata;
        end
        gbf_pkg::REG_WEIGHT_INNER_CORNER: begin
          weights.inner_corner <= cfg.wdata;
        end
        gbf_pkg::REG_WEIGHT_INNER_MID: begin
          weights.inner_mid <= cfg.wdata;
        end
        gbf_pkg::REG_WEIGHT_CENTER: begin
          weights.center <= cfg.wdata;
        end
        default: begin
        end
      endcase
    end
  end

  // Clamp frame geometry to the supported range.
  always_comb begin
    if (image_width < gbf_pkg::WIDTH_W'(gbf_pkg::MIN_DIM)) begin
      eff_width = gbf_pkg::WIDTH_W'(gbf_pkg::MIN_DIM);
    end else if (image_width > gbf_pkg::WIDTH_W'(gbf_pkg::MAX_WIDTH)) begin
      eff_width = gbf_pkg::WIDTH_W'(gbf_pkg::MAX_WIDTH);
    end else begin
      eff_width = image_width;
    end
    if (image_height < gbf_pkg::HEIGHT_W'(gbf_pkg::MIN_DIM)) begin
      eff_height = gbf_pkg::HEIGHT_W'(gbf_pkg::MIN_DIM);
    end else if (image_height > gbf_pkg::HEIGHT_W'(gbf_pkg::MAX_HEIGHT)) begin
      eff_height = gbf_pkg::HEIGHT_W'(gbf_pkg::MAX_HEIGHT);
    end else begin
      eff_height = image_height;
    end
  end

  gbf_linebuf u_linebuf (
    .clk       (clk),
    .rst       (rst),
    .pix       (pix),
    .width     (eff_width),
    .height    (eff_height),
    .win_ctrl  (win_ctrl),
    .window    (window),
    .win_ready (win_ready)
  );

  gbf_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .win_ctrl  (win_ctrl),
    .window    (window),
    .weights   (weights),
    .win_ready (win_ready),
    .res       (res)
  );

endmodule
`default_nettype wire

[sim/tb_gaussian_blur_5x5_filter.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gaussian_blur_5x5_filter
// Streams raster frames into the 5x5 blur filter and checks every filtered
// pixel, with its row and column, against a cycle-free predictor of the line
// stores and window. Covers the reset kernel, clamped and tall frame sizes,
// saturating and zero kernels, back-to-back frames, frames cut short and
// geometry changes mid-frame, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_gaussian_blur_5x5_filter;
  import gbf_pkg::*;

  localparam int DRAIN_CYCLES   = 12;
  localparam int STALL_LIMIT    = 2000;
  localparam int RANDOM_ITEMS   = 160;
  localparam int MAX_REPORTS    = 10;
  localparam int IDLE_PCT       = 15;
  localparam int RAND_MAX_WIDTH = 12;
  localparam int TALL_ROWS      = 16;

  typedef enum int {
    FILL_RANDOM,
    FILL_BINARY,
    FILL_WHITE,
    FILL_BLACK
  } fill_t;

  typedef struct packed {
    pix_t             value;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } blurred_t;

  logic clk;
  logic rst;

  gbf_pix_if pix ();
  gbf_res_if res ();
  gbf_cfg_if cfg ();

  gaussian_blur_5x5_filter dut (
    .clk (clk),
    .rst (rst),
    .pix (pix),
    .res (res),
    .cfg (cfg)
  );

  logic [WEIGHT_W-1:0] reg_file [8];
  pix_t                line_mem [LINES][MAX_WIDTH];
  pix_t                win      [KERNEL][KERNEL];
  int unsigned         col_cnt;
  int unsigned         row_cnt;

  pix_t        raster_q [$];
  blurred_t    blurred_q [$];
  blurred_t    head;
  logic        pix_fire;
  logic        quiet;
  int unsigned stall_cycles;
  int unsigned mismatches;
  int unsigned pixels_in;
  int unsigned results_seen;
  int unsigned phases;

  always #5 clk = ~clk;

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [WEIGHT_W-1:0] kernel_weight(input int y, input int x);
    int dy;
    int dx;
    int lo;
    int hi;
    reg_idx_t sel;
    dy = (y >= HALF) ? y - HALF : HALF - y;
    dx = (x >= HALF) ? x - HALF : HALF - x;
    lo = (dy < dx) ? dy : dx;
    hi = (dy < dx) ? dx : dy;
    if (hi == 0) begin
      sel = REG_WEIGHT_CENTER;
    end else if (hi == 1) begin
      sel = (lo == 0) ? REG_WEIGHT_INNER_MID : REG_WEIGHT_INNER_CORNER;
    end else if (lo == 0) begin
      sel = REG_WEIGHT_OUTER_MID;
    end else if (lo == 1) begin
      sel = REG_WEIGHT_OUTER_NEAR;
    end else begin
      sel = REG_WEIGHT_CORNER;
    end
    return reg_file[sel];
  endfunction

  task automatic filter_pixel(input pix_t px);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    int unsigned acc;
    int          y;
    int          x;
    blurred_t    e;
    w = clamp_dim(reg_file[REG_IMAGE_WIDTH][WIDTH_W-1:0], MAX_WIDTH);
    h = clamp_dim(reg_file[REG_IMAGE_HEIGHT][HEIGHT_W-1:0], MAX_HEIGHT);
    // wrap a position left past the frame by a geometry change
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= h) row_cnt = 0;
    r = row_cnt;
    c = col_cnt;
    for (y = 0; y < KERNEL; y++)
      for (x = 0; x < KERNEL - 1; x++)
        win[y][x] = win[y][x+1];
    for (y = 0; y < LINES; y++)
      win[y][KERNEL-1] = line_mem[(r + y) % LINES][c];
    win[KERNEL-1][KERNEL-1] = px;
    line_mem[r % LINES][c]  = px;
    if (r >= KERNEL - 1 && c >= KERNEL - 1) begin
      acc = 0;
      for (y = 0; y < KERNEL; y++)
        for (x = 0; x < KERNEL; x++)
          acc += win[y][x] * kernel_weight(y, x);
      acc     = acc >> FRAC_W;
      e.value = (acc > 255) ? 8'hFF : PIX_W'(acc);
      e.row   = ROW_W'(r - HALF);
      e.col   = COL_W'(c - HALF);
      blurred_q.push_back(e);
    end
    col_cnt++;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= h) row_cnt = 0;
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [WEIGHT_W-1:0] val);
    @(negedge clk);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.wdata = val;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_IMAGE_WIDTH:  reg_file[idx] = WEIGHT_W'(val[WIDTH_W-1:0]);
      REG_IMAGE_HEIGHT: reg_file[idx] = WEIGHT_W'(val[HEIGHT_W-1:0]);
      default:          reg_file[idx] = val;
    endcase
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic feed(input int unsigned n, input fill_t fill);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      case (fill)
        FILL_BINARY: raster_q.push_back($urandom_range(1) ? 8'hFF : 8'h00);
        FILL_WHITE:  raster_q.push_back(8'hFF);
        FILL_BLACK:  raster_q.push_back(8'h00);
        default:     raster_q.push_back(PIX_W'($urandom_range(255)));
      endcase
    end
  endtask

  // hold until every pixel is taken and every result is back, then drain
  task automatic settle();
    while (raster_q.size() != 0 || pix.valid || blurred_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    phases++;
  endtask

  always @(negedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
    end else if (!pix.valid || pix_fire) begin
      if (raster_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        pix.valid    <= 1'b1;
        pix.pixel_in <= raster_q.pop_front();
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    res.ready <= !rst && (quiet || $urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    pix_fire <= !rst && pix.valid && pix.ready;
    if (!rst) begin
      if (pix.valid && pix.ready) begin
        filter_pixel(pix.pixel_in);
        pixels_in++;
      end
      if (res.valid && res.ready) begin
        results_seen++;
        if (blurred_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("ERROR: unexpected result value=%0d row=%0d col=%0d",
                     res.pixel_out, res.out_row, res.out_col);
        end else begin
          head = blurred_q.pop_front();
          if (res.pixel_out !== head.value || res.out_row !== head.row ||
              res.out_col !== head.col) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("ERROR: expected value=%0d row=%0d col=%0d, got value=%0d row=%0d col=%0d",
                       head.value, head.row, head.col,
                       res.pixel_out, res.out_row, res.out_col);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (res.valid && res.ready) ||
        (cfg.valid && cfg.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("ERROR: no transaction for %0d cycles, %0d results outstanding",
               STALL_LIMIT, blurred_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned n;
    int unsigned rand_items;
    int          i;
    int          j;
    clk          = 1'b0;
    rst          = 1'b1;
    quiet        = 1'b0;
    pix.valid    = 1'b0;
    pix.pixel_in = '0;
    res.ready    = 1'b0;
    cfg.valid    = 1'b0;
    cfg.index    = REG_IMAGE_WIDTH;
    cfg.wdata    = '0;
    stall_cycles = 0;
    mismatches   = 0;
    pixels_in    = 0;
    results_seen = 0;
    phases       = 0;
    col_cnt      = 0;
    row_cnt      = 0;
    reg_file[REG_IMAGE_WIDTH]         = WEIGHT_W'(RST_IMAGE_WIDTH);
    reg_file[REG_IMAGE_HEIGHT]        = WEIGHT_W'(RST_IMAGE_HEIGHT);
    reg_file[REG_WEIGHT_CORNER]       = RST_WEIGHT_CORNER;
    reg_file[REG_WEIGHT_OUTER_NEAR]   = RST_WEIGHT_OUT_NEAR;
    reg_file[REG_WEIGHT_OUTER_MID]    = RST_WEIGHT_OUT_MID;
    reg_file[REG_WEIGHT_INNER_CORNER] = RST_WEIGHT_IN_CORNER;
    reg_file[REG_WEIGHT_INNER_MID]    = RST_WEIGHT_IN_MID;
    reg_file[REG_WEIGHT_CENTER]       = RST_WEIGHT_CENTER;
    for (i = 0; i < LINES; i++)
      for (j = 0; j < MAX_WIDTH; j++)
        line_mem[i][j] = '0;
    for (i = 0; i < KERNEL; i++)
      for (j = 0; j < KERNEL; j++)
        win[i][j] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset kernel; this frame fills every line store entry used below
    write_reg(REG_IMAGE_WIDTH, WEIGHT_W'(RAND_MAX_WIDTH));
    write_reg(REG_IMAGE_HEIGHT, WEIGHT_W'(MIN_DIM));
    feed(RAND_MAX_WIDTH * MIN_DIM, FILL_RANDOM);
    settle();

    // smallest frame, all weights at maximum: saturate
    write_reg(REG_IMAGE_WIDTH, WEIGHT_W'(MIN_DIM));
    for (i = REG_WEIGHT_CORNER; i <= REG_WEIGHT_CENTER; i++)
      write_reg(reg_idx_t'(i), 16'hFFFF);
    feed(MIN_DIM * MIN_DIM, FILL_WHITE);
    settle();

    for (i = REG_WEIGHT_CORNER; i <= REG_WEIGHT_CENTER; i++)
      write_reg(reg_idx_t'(i), 16'h0000);
    feed(MIN_DIM * MIN_DIM, FILL_BINARY);
    settle();

    for (i = REG_WEIGHT_CORNER; i <= REG_WEIGHT_CENTER; i++)
      write_reg(reg_idx_t'(i), WEIGHT_W'($urandom_range(2000)));
    feed(MIN_DIM * MIN_DIM, FILL_BLACK);
    feed(MIN_DIM * MIN_DIM, FILL_WHITE);
    settle();

    // clamp width and height up to the minimum
    write_reg(REG_IMAGE_WIDTH, 16'h0000);
    write_reg(REG_IMAGE_HEIGHT, 16'h0000);
    feed(MIN_DIM * MIN_DIM, FILL_RANDOM);
    settle();

    // height clamped to the maximum, rows past the usual wrap, no stall
    quiet = 1'b1;
    write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
    feed(MIN_DIM * TALL_ROWS, FILL_RANDOM);
    settle();
    quiet = 1'b0;
    write_reg(REG_IMAGE_HEIGHT, WEIGHT_W'(MIN_DIM));

    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 60) begin
        if ($urandom_range(99) < 5)
          write_reg(REG_IMAGE_WIDTH, WEIGHT_W'($urandom_range(MIN_DIM - 1)));
        else
          write_reg(REG_IMAGE_WIDTH, WEIGHT_W'($urandom_range(RAND_MAX_WIDTH, MIN_DIM)));
      end
      if ($urandom_range(99) < 60)
        write_reg(REG_IMAGE_HEIGHT, ($urandom_range(99) < 5) ?
                  WEIGHT_W'($urandom_range(MIN_DIM - 1)) : WEIGHT_W'($urandom_range(8, 5)));
      for (i = REG_WEIGHT_CORNER; i <= REG_WEIGHT_CENTER; i++)
        if ($urandom_range(1))
          write_reg(reg_idx_t'(i), ($urandom_range(9) == 0) ?
                    WEIGHT_W'($urandom_range(16'hFFFF)) : WEIGHT_W'($urandom_range(4000)));
      w = clamp_dim(reg_file[REG_IMAGE_WIDTH][WIDTH_W-1:0], MAX_WIDTH);
      h = clamp_dim(reg_file[REG_IMAGE_HEIGHT][HEIGHT_W-1:0], MAX_HEIGHT);
      n = w * h;
      // cut the frame short so the next setting lands mid-frame
      if ($urandom_range(99) < 15) n = n - $urandom_range(w * h - 1, 1);
      feed(n, ($urandom_range(99) < 80) ? FILL_RANDOM : FILL_BINARY);
      rand_items += n;
      settle();
    end

    $display("Summary: %0d pixels over %0d register settings, frames up to %0d wide",
             pixels_in, phases, RAND_MAX_WIDTH);
    $display("Summary: %0d filtered pixels checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && blurred_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
